// ===== hdl/length_prefixed_frame_deframer_macros.svh =====
// assertion macros for the length-prefixed frame deframer checker
// no dependencies; included by the checker file
`ifndef LENGTH_PREFIXED_FRAME_DEFRAMER_MACROS_SVH
`define LENGTH_PREFIXED_FRAME_DEFRAMER_MACROS_SVH

// concurrent assertion on an explicit clock and active-low reset
`define LPFD_ASSERT_CLK(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// concurrent assertion on the block clock and reset
`define LPFD_ASSERT(label, prop, msg) \
  `LPFD_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

// ===== hdl/lpfd_pkg.sv =====
// package for the length-prefixed frame deframer: header field sizes and phase codes
// no dependencies
`default_nettype none

package lpfd_pkg;

  localparam int VersionBytesRaw     = 1;
  localparam int TypeBytesRaw        = 1;
  localparam int FlagsBytesRaw       = 1;
  localparam int CorrelationBytesRaw = 4;
  localparam int LengthBytesRaw      = 4;

  // field sizes clamped to 1..8 bytes
  localparam logic [3:0] VersionBytes =
    4'(VersionBytesRaw < 1 ? 1 : (VersionBytesRaw > 8 ? 8 : VersionBytesRaw));
  localparam logic [3:0] TypeBytes =
    4'(TypeBytesRaw < 1 ? 1 : (TypeBytesRaw > 8 ? 8 : TypeBytesRaw));
  localparam logic [3:0] FlagsBytes =
    4'(FlagsBytesRaw < 1 ? 1 : (FlagsBytesRaw > 8 ? 8 : FlagsBytesRaw));
  localparam logic [3:0] CorrelationBytes =
    4'(CorrelationBytesRaw < 1 ? 1 : (CorrelationBytesRaw > 8 ? 8 : CorrelationBytesRaw));
  localparam logic [3:0] LengthBytes =
    4'(LengthBytesRaw < 1 ? 1 : (LengthBytesRaw > 8 ? 8 : LengthBytesRaw));

  localparam logic [2:0] PhVersion = 3'd0;
  localparam logic [2:0] PhType    = 3'd1;
  localparam logic [2:0] PhFlags   = 3'd2;
  localparam logic [2:0] PhCorr    = 3'd3;
  localparam logic [2:0] PhLength  = 3'd4;
  localparam logic [2:0] PhBody    = 3'd5;

  localparam logic KindHeader = 1'b0;
  localparam logic KindBody   = 1'b1;

  function automatic logic [3:0] field_size(input logic [2:0] phase);
    logic [3:0] size;
    case (phase)
      PhVersion: size = VersionBytes;
      PhType:    size = TypeBytes;
      PhFlags:   size = FlagsBytes;
      PhCorr:    size = CorrelationBytes;
      default:   size = LengthBytes;
    endcase
    return size;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/length_prefixed_frame_deframer.sv =====
// length-prefixed frame deframer top level: header parse, body pass-through, result register
// depends on lpfd_pkg
//
// usage:
//   input channel: one stream byte per transaction on data_byte_i (in_valid_i / in_stall_o)
//   output channel: one result per transaction (out_valid_o / out_stall_i); kind_o is 0
//     for a header result carrying version, type, flags, correlation id and body length,
//     1 for a body byte; frame_end_o marks the result that closes the frame
//   header bytes other than the last of the header give no result
//   result timing: a result is registered and shown on the output in the cycle after its input transaction
//   throughput: one byte per cycle while no held result is stalled, set by the shift and count
//     update done per byte and the one-entry result register
//   receiver stall: while a result is held and out_stall_i is high, in_stall_o is high;
//     in_stall_o drops in the cycle the held result is taken
//   reset: parser returns to the version field with empty accumulator, no result held
`default_nettype none

module length_prefixed_frame_deframer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             kind_o,
  output logic [7:0]       version_o,
  output logic [7:0]       frame_type_o,
  output logic [7:0]       frame_flags_o,
  output logic [31:0]      request_tag_o,
  output logic [31:0]      body_length_o,
  output logic [7:0]       body_byte_o,
  output logic             frame_end_o
);
  import lpfd_pkg::*;

  logic [2:0]  phase_q, phase_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [31:0] acc_q, acc_d;
  logic [7:0]  version_q, version_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  flags_q, flags_d;
  logic [31:0] corr_q, corr_d;
  logic [31:0] rem_q, rem_d;

  logic        out_valid_q;
  logic        kind_q, kind_d;
  logic [7:0]  ver_out_q, ver_out_d;
  logic [7:0]  type_out_q, type_out_d;
  logic [7:0]  flags_out_q, flags_out_d;
  logic [31:0] corr_out_q, corr_out_d;
  logic [31:0] len_out_q, len_out_d;
  logic [7:0]  body_q, body_d;
  logic        end_q, end_d;

  logic        accept;
  logic        res_valid;
  logic [31:0] acc_shift;
  logic [3:0]  cnt_inc;
  logic        field_done;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign acc_shift  = {acc_q[23:0], data_byte_i};
  assign cnt_inc    = cnt_q + 4'd1;
  assign field_done = cnt_inc >= field_size(phase_q);

  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    acc_d       = acc_q;
    version_d   = version_q;
    type_d      = type_q;
    flags_d     = flags_q;
    corr_d      = corr_q;
    rem_d       = rem_q;
    res_valid   = 1'b0;
    kind_d      = KindHeader;
    ver_out_d   = '0;
    type_out_d  = '0;
    flags_out_d = '0;
    corr_out_d  = '0;
    len_out_d   = '0;
    body_d      = '0;
    end_d       = 1'b0;
    case (phase_q)
      PhBody: begin
        rem_d     = rem_q - 32'd1;
        res_valid = 1'b1;
        kind_d    = KindBody;
        body_d    = data_byte_i;
        end_d     = (rem_d == '0);
        if (end_d) begin
          phase_d = PhVersion;
        end
      end
      PhVersion, PhType, PhFlags, PhCorr, PhLength: begin
        acc_d = acc_shift;
        cnt_d = cnt_inc;
        if (field_done) begin
          acc_d = '0;
          cnt_d = '0;
          case (phase_q)
            PhVersion: begin
              version_d = acc_shift[7:0];
              phase_d   = PhType;
            end
            PhType: begin
              type_d  = acc_shift[7:0];
              phase_d = PhFlags;
            end
            PhFlags: begin
              flags_d = acc_shift[7:0];
              phase_d = PhCorr;
            end
            PhCorr: begin
              corr_d  = acc_shift;
              phase_d = PhLength;
            end
            default: begin
              rem_d       = acc_shift;
              res_valid   = 1'b1;
              ver_out_d   = version_q;
              type_out_d  = type_q;
              flags_out_d = flags_q;
              corr_out_d  = corr_q;
              len_out_d   = acc_shift;
              end_d       = (acc_shift == '0);
              phase_d     = end_d ? PhVersion : PhBody;
            end
          endcase
        end
      end
      default: begin
        phase_d = PhVersion;
        cnt_d   = '0;
        acc_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhVersion;
      cnt_q     <= '0;
      acc_q     <= '0;
      version_q <= '0;
      type_q    <= '0;
      flags_q   <= '0;
      corr_q    <= '0;
      rem_q     <= '0;
    end else if (accept) begin
      phase_q   <= phase_d;
      cnt_q     <= cnt_d;
      acc_q     <= acc_d;
      version_q <= version_d;
      type_q    <= type_d;
      flags_q   <= flags_d;
      corr_q    <= corr_d;
      rem_q     <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && res_valid) begin
      kind_q      <= kind_d;
      ver_out_q   <= ver_out_d;
      type_out_q  <= type_out_d;
      flags_out_q <= flags_out_d;
      corr_out_q  <= corr_out_d;
      len_out_q   <= len_out_d;
      body_q      <= body_d;
      end_q       <= end_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign version_o     = ver_out_q;
  assign frame_type_o  = type_out_q;
  assign frame_flags_o = flags_out_q;
  assign request_tag_o = corr_out_q;
  assign body_length_o = len_out_q;
  assign body_byte_o   = body_q;
  assign frame_end_o   = end_q;

endmodule

`default_nettype wire

// ===== hdl/lpfd_checker.sv =====
// port-level checker for the length-prefixed frame deframer, bound to the top level
// depends on length_prefixed_frame_deframer_macros.svh and lpfd_pkg
`default_nettype none

`include "length_prefixed_frame_deframer_macros.svh"

module lpfd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic [7:0]  data_byte_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic        kind_o,
  input wire logic [7:0]  version_o,
  input wire logic [7:0]  frame_type_o,
  input wire logic [7:0]  frame_flags_o,
  input wire logic [31:0] request_tag_o,
  input wire logic [31:0] body_length_o,
  input wire logic [7:0]  body_byte_o,
  input wire logic        frame_end_o
);
  import lpfd_pkg::*;

  `LPFD_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) && $stable(body_byte_o) && $stable(body_length_o) && $stable(frame_end_o), "stalled result changed")
  `LPFD_ASSERT(a_no_accept_when_full, out_valid_o && out_stall_i |-> in_stall_o, "input taken while result held")
  `LPFD_ASSERT(a_header_end, out_valid_o && kind_o == KindHeader |-> frame_end_o == (body_length_o == '0) && body_byte_o == '0, "header result end flag wrong")
  `LPFD_ASSERT(a_body_zero, out_valid_o && kind_o == KindBody |-> version_o == '0 && frame_type_o == '0 && frame_flags_o == '0 && request_tag_o == '0 && body_length_o == '0, "body result carries header fields")
  `LPFD_ASSERT(a_no_stall_idle, !out_valid_o |-> !in_stall_o, "input stalled with empty output")

  logic unused_in;
  assign unused_in = in_valid_i ^ (^data_byte_i);

endmodule

bind length_prefixed_frame_deframer lpfd_checker u_lpfd_checker (.*);

`default_nettype wire

// ===== bench/deframer_checker.sv =====
// checker for the length-prefixed frame deframer: watches both channels, predicts results
// from the accepted stream bytes and compares each accepted result field by field
// depends on lpfd_pkg
`timescale 1ns / 100ps

module deframer_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  data_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        kind_i,
  input  logic [7:0]  version_i,
  input  logic [7:0]  frame_type_i,
  input  logic [7:0]  frame_flags_i,
  input  logic [31:0] request_tag_i,
  input  logic [31:0] body_length_i,
  input  logic [7:0]  body_byte_i,
  input  logic        frame_end_i,
  output int          failures_o,
  output int          pending_o
);
  import lpfd_pkg::*;

  typedef struct packed {
    logic        kind;
    logic [7:0]  version;
    logic [7:0]  frame_type;
    logic [7:0]  frame_flags;
    logic [31:0] request_tag;
    logic [31:0] body_length;
    logic [7:0]  body_byte;
    logic        frame_end;
  } frame_result_t;

  frame_result_t expected_results[$];
  int mismatches = 0;

  logic [2:0]  hdr_phase;
  logic [3:0]  bytes_in_field;
  logic [63:0] field_shift;
  logic [7:0]  hdr_version;
  logic [7:0]  hdr_type;
  logic [7:0]  hdr_flags;
  logic [31:0] hdr_corr;
  logic [31:0] body_left;

  function automatic logic [3:0] field_width_bytes(input logic [2:0] ph);
    logic [3:0] n;
    n = LengthBytes;
    if (ph == PhVersion) n = VersionBytes;
    else if (ph == PhType) n = TypeBytes;
    else if (ph == PhFlags) n = FlagsBytes;
    else if (ph == PhCorr) n = CorrelationBytes;
    return n;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, got);
      end
    end
  endtask

  task automatic predict_byte(input logic [7:0] b);
    frame_result_t r;
    logic [63:0] word;
    r = '0;
    if (hdr_phase == PhBody) begin
      body_left = body_left - 32'd1;
      r.kind = KindBody;
      r.body_byte = b;
      if (body_left == 32'd0) begin
        r.frame_end = 1'b1;
        hdr_phase = PhVersion;
      end
      expected_results.push_back(r);
    end else if (hdr_phase > PhLength) begin
      hdr_phase = PhVersion;
      bytes_in_field = '0;
      field_shift = '0;
    end else begin
      field_shift = {field_shift[55:0], b};
      bytes_in_field = bytes_in_field + 4'd1;
      if (bytes_in_field >= field_width_bytes(hdr_phase)) begin
        word = field_shift;
        field_shift = '0;
        bytes_in_field = '0;
        case (hdr_phase)
          PhVersion: begin
            hdr_version = word[7:0];
            hdr_phase = PhType;
          end
          PhType: begin
            hdr_type = word[7:0];
            hdr_phase = PhFlags;
          end
          PhFlags: begin
            hdr_flags = word[7:0];
            hdr_phase = PhCorr;
          end
          PhCorr: begin
            hdr_corr = word[31:0];
            hdr_phase = PhLength;
          end
          default: begin
            body_left = word[31:0];
            r.kind = KindHeader;
            r.version = hdr_version;
            r.frame_type = hdr_type;
            r.frame_flags = hdr_flags;
            r.request_tag = hdr_corr;
            r.body_length = body_left;
            r.frame_end = (body_left == 32'd0);
            hdr_phase = (body_left == 32'd0) ? PhVersion : PhBody;
            expected_results.push_back(r);
          end
        endcase
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    frame_result_t want;
    if (!rst_ni) begin
      hdr_phase = PhVersion;
      bytes_in_field = '0;
      field_shift = '0;
      hdr_version = '0;
      hdr_type = '0;
      hdr_flags = '0;
      hdr_corr = '0;
      body_left = '0;
      expected_results.delete();
      failures_o <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result with nothing expected, kind %b", $realtime, kind_i);
          end
        end else begin
          want = expected_results.pop_front();
          check_field("kind", 32'(want.kind), 32'(kind_i));
          check_field("version", 32'(want.version), 32'(version_i));
          check_field("frame_type", 32'(want.frame_type), 32'(frame_type_i));
          check_field("frame_flags", 32'(want.frame_flags), 32'(frame_flags_i));
          check_field("request_tag", want.request_tag, request_tag_i);
          check_field("body_length", want.body_length, body_length_i);
          check_field("body_byte", 32'(want.body_byte), 32'(body_byte_i));
          check_field("frame_end", 32'(want.frame_end), 32'(frame_end_i));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predict_byte(data_byte_i);
      end
      failures_o <= mismatches;
      pending_o <= expected_results.size();
    end
  end

endmodule

// ===== bench/tb.sv =====
// top of the deframer testbench: clock, reset, byte stream stimulus, receiver stalls, verdict
// depends on lpfd_pkg, length_prefixed_frame_deframer and deframer_checker
`timescale 1ns / 100ps

module tb;
  import lpfd_pkg::*;

  localparam int CycleLimit = 200000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        kind_o;
  logic [7:0]  version_o;
  logic [7:0]  frame_type_o;
  logic [7:0]  frame_flags_o;
  logic [31:0] request_tag_o;
  logic [31:0] body_length_o;
  logic [7:0]  body_byte_o;
  logic        frame_end_o;

  int failures;
  int pending;
  int cycle_count = 0;
  logic calm;
  logic [7:0] stream_bytes[$];

  length_prefixed_frame_deframer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .version_o     (version_o),
    .frame_type_o  (frame_type_o),
    .frame_flags_o (frame_flags_o),
    .request_tag_o (request_tag_o),
    .body_length_o (body_length_o),
    .body_byte_o   (body_byte_o),
    .frame_end_o   (frame_end_o)
  );

  deframer_checker frame_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_i        (kind_o),
    .version_i     (version_o),
    .frame_type_i  (frame_type_o),
    .frame_flags_i (frame_flags_o),
    .request_tag_i (request_tag_o),
    .body_length_i (body_length_o),
    .body_byte_i   (body_byte_o),
    .frame_end_i   (frame_end_o),
    .failures_o    (failures),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  assign calm = (cycle_count >= 300) && (cycle_count < 600);

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic push_field(input logic [63:0] value, input logic [3:0] nbytes);
    for (int i = int'(nbytes) - 1; i >= 0; i--) begin
      stream_bytes.push_back(value[8*i +: 8]);
    end
  endtask

  // header, then at most body_cap body bytes of the length that the block decodes
  task automatic push_frame(input logic [63:0] ver, input logic [63:0] typ,
                            input logic [63:0] flg, input logic [63:0] corr,
                            input logic [63:0] len, input int body_cap,
                            input logic [7:0] fill);
    logic [63:0] kept;
    longint unsigned body;
    push_field(ver, VersionBytes);
    push_field(typ, TypeBytes);
    push_field(flg, FlagsBytes);
    push_field(corr, CorrelationBytes);
    push_field(len, LengthBytes);
    kept = (LengthBytes >= 8) ? len : (len & ((64'd1 << (8 * LengthBytes)) - 64'd1));
    body = kept[31:0];
    for (longint unsigned i = 0; i < body && i < body_cap; i++) begin
      stream_bytes.push_back((fill == 8'h00) ? 8'($urandom) : fill);
    end
  endtask

  task automatic build_stream();
    int pick;
    logic [63:0] len;
    // zero-length body: frame ends in its header result
    push_frame(64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 1 << 30, 8'hff);
    // all-ones header fields with a single body byte
    push_frame('1, '1, '1, '1, 64'd1, 1 << 30, 8'hff);
    while (stream_bytes.size() < 630) begin
      pick = $urandom_range(99);
      if (pick < 70) len = $urandom_range(6, 0);
      else if (pick < 95) len = $urandom_range(20, 7);
      else len = $urandom_range(64, 21);
      len[63:32] = $urandom;
      push_frame({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, len, 1 << 30, 8'h00);
    end
    // largest body length, left open after five body bytes
    push_frame({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
               {$urandom, $urandom}, '1, 5, 8'h00);
  endtask

  initial begin : receiver
    int hold;
    hold = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (cycle_count == 150) hold = 80;
      if (hold != 0) begin
        hold--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !calm && ($urandom_range(99) < 21);
      end
    end
  end

  initial begin : stimulus
    int sent;
    int drain;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    data_byte_i = 8'h00;
    build_stream();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    sent = 0;
    while (sent < stream_bytes.size()) begin
      @(posedge clk_i);
      if (in_valid_i && !in_stall_o) sent++;
      if (!in_valid_i || !in_stall_o) begin
        if (sent < stream_bytes.size() && (calm || $urandom_range(99) >= 21)) begin
          in_valid_i <= 1'b1;
          data_byte_i <= stream_bytes[sent];
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
    repeat (2) @(posedge clk_i);
    drain = 0;
    while (pending != 0 && drain < 5000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (10) @(posedge clk_i);
    if (failures == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
